@@ hw/rtl/esv_pkg.sv @@
// ----------------------------------------------------------------------------
// Encoder sample validator package
// Shared widths, codes and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package esv_pkg;

    // Encoder geometry: one full turn spans the whole reading range
    localparam int POS_W      = 14;
    localparam int RESOLUTION = 1 << POS_W;
    localparam int HALF_RES   = RESOLUTION / 2;

    // Startup vote
    localparam int VOTE_COUNT = 8;
    localparam int VOTE_AW    = (VOTE_COUNT > 1) ? $clog2(VOTE_COUNT) : 1;
    localparam int VOTE_NW    = $clog2(VOTE_COUNT + 1);

    // Register and counter widths
    localparam int TOL_W      = 13;
    localparam int LIMIT_W    = 8;
    localparam int CNT_W      = LIMIT_W + 1;
    localparam int LIM_W      = TOL_W + CNT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int FAULT_W    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_TOL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENFORCE_DIR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_SENSE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REV_TOL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REV_LIMIT   = 3'd5;

    // Operation codes
    localparam logic OP_READING = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_SKIP = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_DIR  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic take;       // latch the input transfer
        logic restart;    // clear fault and counters, re-arm vote
        logic vote_wr;    // store the reading in the vote memory
        logic vote_init;  // start the vote walk
        logic rd_cur;     // read candidate entry i
        logic ld_cur;     // capture candidate, start counting at entry 0
        logic count;      // compare entry j against candidate
        logic vote_done;  // take the winner as tracking point
        logic track;      // evaluate a tracked reading
        logic load_out;   // move the result into the output register
    } esv_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic faulted;
        logic voting;
        logic fill_last;
        logic j_last;
        logic i_last;
    } esv_sts_t;

endpackage

@@ hw/rtl/encoder_sample_validator.sv @@
// ----------------------------------------------------------------------------
// Encoder sample validator
// Checks absolute encoder readings against a voted tracking point.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one item: op (reading or restart) and the reading.
//   m_ channel returns exactly one result per item: emit, position, faulted
//   and fault_kind. cfg_ channel writes one register per transfer and is
//   always ready. The user must write it only while the block is idle;
//   the block itself does not enforce this.
// Sequencing: one item is in work at a time; s_ready is high only when idle.
//   Restart, ignored (faulted) and voting readings go from the input transfer
//   to the response state; tracked readings pass the track state first (the
//   tolerance product is formed at the transfer, the compare in that state).
//   The reading that completes the vote walks the vote memory through its
//   single read port, candidate by candidate.
// Reset: registers return to their defaults, counters and fault clear and
//   the vote re-arms. The vote memory is not cleared; it is always filled
//   before it is read.
// Stall: a finished result sits in the output register; the next item is
//   taken meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
module encoder_sample_validator
    import esv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [POS_W-1:0]      s_reading,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_emit,
    output logic [POS_W-1:0]      m_position,
    output logic                  m_faulted,
    output logic [FAULT_W-1:0]    m_fault_kind,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    esv_cmd_t cmd;
    esv_sts_t sts;

    // Register writes are always accepted
    assign cfg_ready = 1'b1;

    esv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    esv_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_reading    (s_reading),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_emit       (m_emit),
        .m_position   (m_position),
        .m_faulted    (m_faulted),
        .m_fault_kind (m_fault_kind)
    );

endmodule

@@ hw/rtl/esv_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module esv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [WIDTH-1:0]     rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/esv_ctrl.sv @@
// ----------------------------------------------------------------------------
// Encoder sample validator controller
// Sequences input transfers, the startup vote walk and the result transfer.
// ----------------------------------------------------------------------------
module esv_ctrl
    import esv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_op,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  esv_sts_t sts,
    output esv_cmd_t cmd
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRACK,
        ST_RD_CUR,
        ST_LD_CUR,
        ST_COUNT,
        ST_SET,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Decode commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take = 1'b1;
                    if (s_op == OP_RESTART) begin
                        cmd.restart = 1'b1;
                        state_next  = ST_RESP;
                    end else if (sts.faulted) begin
                        state_next = ST_RESP;
                    end else if (sts.voting) begin
                        cmd.vote_wr = 1'b1;
                        if (sts.fill_last) begin
                            cmd.vote_init = 1'b1;
                            state_next    = ST_RD_CUR;
                        end else begin
                            state_next = ST_RESP;
                        end
                    end else begin
                        state_next = ST_TRACK;
                    end
                end
            end
            ST_TRACK: begin
                cmd.track  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RD_CUR: begin
                cmd.rd_cur = 1'b1;
                state_next = ST_LD_CUR;
            end
            ST_LD_CUR: begin
                cmd.ld_cur = 1'b1;
                state_next = ST_COUNT;
            end
            ST_COUNT: begin
                cmd.count = 1'b1;
                if (sts.j_last) begin
                    state_next = sts.i_last ? ST_SET : ST_RD_CUR;
                end
            end
            ST_SET: begin
                cmd.vote_done = 1'b1;
                state_next    = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold the result valid until the receiver takes it
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ hw/rtl/esv_dp.sv @@
// ----------------------------------------------------------------------------
// Encoder sample validator datapath
// Configuration registers, tracking state, vote memory and result register.
// ----------------------------------------------------------------------------
module esv_dp
    import esv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  esv_cmd_t              cmd,
    output esv_sts_t              sts,
    input  logic [POS_W-1:0]      s_reading,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_emit,
    output logic [POS_W-1:0]      m_position,
    output logic                  m_faulted,
    output logic [FAULT_W-1:0]    m_fault_kind
);
    // Configuration
    logic [TOL_W-1:0]   skip_tol_reg;
    logic [LIMIT_W-1:0] skip_limit_reg;
    logic               enforce_reg;
    logic               sense_reg;
    logic [TOL_W-1:0]   rev_tol_reg;
    logic [LIMIT_W-1:0] rev_limit_reg;

    // Tracking state
    logic [POS_W-1:0]   reading_reg;
    logic [POS_W-1:0]   tp_reg;
    logic [CNT_W-1:0]   skip_cnt_reg;
    logic [CNT_W-1:0]   ww_cnt_reg;
    logic [FAULT_W-1:0] fault_reg;
    logic               voting_reg;
    logic [VOTE_AW-1:0] fill_reg;
    logic [LIM_W-1:0]   lim_reg;
    logic               res_emit_reg;

    // Vote walk
    logic [VOTE_AW-1:0] i_reg;
    logic [VOTE_AW-1:0] j_reg;
    logic [VOTE_NW-1:0] n_reg;
    logic [VOTE_NW-1:0] best_n_reg;
    logic [POS_W-1:0]   cur_reg;
    logic [POS_W-1:0]   best_reg;

    // Output register
    logic               m_emit_reg;
    logic [POS_W-1:0]   m_position_reg;
    logic               m_faulted_reg;
    logic [FAULT_W-1:0] m_fault_kind_reg;

    logic [VOTE_AW-1:0] ram_rd_addr;
    logic [POS_W-1:0]   ram_rd_data;
    logic [VOTE_NW-1:0] n_sum;

    logic [POS_W-1:0]   diff;
    logic signed [POS_W:0] dx;
    logic signed [POS_W:0] fwd;
    logic signed [POS_W:0] back;
    logic [POS_W:0]     abs_dx;
    logic signed [LIM_W:0] fwd_w;
    logic signed [LIM_W:0] lim_s;
    logic               accept;
    logic               hold;
    logic               skip_inc;
    logic               ww_inc;
    logic [CNT_W-1:0]   skip_n;
    logic [CNT_W-1:0]   ww_n;
    logic [FAULT_W-1:0] fault_n;

    // Vote memory
    esv_ram #(
        .WIDTH (POS_W),
        .DEPTH (VOTE_COUNT)
    ) u_vote_ram (
        .aclk    (aclk),
        .wr_en   (cmd.vote_wr),
        .wr_addr (fill_reg),
        .wr_data (s_reading),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Select read address: candidate, first entry, or next compare entry
    always_comb begin
        priority if (cmd.rd_cur) begin
            ram_rd_addr = i_reg;
        end else if (cmd.ld_cur) begin
            ram_rd_addr = '0;
        end else begin
            ram_rd_addr = j_reg + VOTE_AW'(1);
        end
    end

    assign n_sum = n_reg + VOTE_NW'(ram_rd_data == cur_reg);

    // Wrapped signed delta and the skip / direction decision
    always_comb begin
        diff = reading_reg - tp_reg;
        if (diff > POS_W'(HALF_RES)) begin
            dx = {1'b0, diff} - (POS_W+1)'(RESOLUTION);
        end else begin
            dx = {1'b0, diff};
        end
        fwd    = sense_reg ? -dx : dx;
        back   = -fwd;
        abs_dx = dx[POS_W] ? -dx : dx;
        fwd_w  = (LIM_W+1)'(fwd);
        lim_s  = signed'({1'b0, lim_reg});

        accept   = 1'b0;
        hold     = 1'b0;
        skip_inc = 1'b0;
        ww_inc   = 1'b0;
        if (enforce_reg) begin
            if (fwd_w > lim_s) begin
                skip_inc = 1'b1;
            end else if (fwd[POS_W]) begin
                if (back > signed'((POS_W+1)'(rev_tol_reg))) begin
                    ww_inc = 1'b1;
                end else begin
                    hold = 1'b1;
                end
            end else begin
                accept = 1'b1;
            end
        end else begin
            if (LIM_W'(abs_dx) > lim_reg) begin
                skip_inc = 1'b1;
            end else begin
                accept = 1'b1;
            end
        end

        skip_n = skip_cnt_reg;
        ww_n   = ww_cnt_reg;
        if (skip_inc) begin
            skip_n = skip_cnt_reg + CNT_W'(1);
        end
        if (ww_inc) begin
            ww_n = ww_cnt_reg + CNT_W'(1);
        end
        if (accept || hold) begin
            skip_n = '0;
            ww_n   = '0;
        end

        priority if (skip_n > CNT_W'(skip_limit_reg)) begin
            fault_n = FAULT_SKIP;
        end else if (ww_n > CNT_W'(rev_limit_reg)) begin
            fault_n = FAULT_DIR;
        end else begin
            fault_n = FAULT_NONE;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_tol_reg   <= TOL_W'(1);
            skip_limit_reg <= LIMIT_W'(1);
            enforce_reg    <= 1'b0;
            sense_reg      <= 1'b0;
            rev_tol_reg    <= TOL_W'(1);
            rev_limit_reg  <= LIMIT_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SKIP_TOL:    skip_tol_reg   <= cfg_data;
                REG_SKIP_LIMIT:  skip_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_ENFORCE_DIR: enforce_reg    <= cfg_data[0];
                REG_ROT_SENSE:   sense_reg      <= cfg_data[0];
                REG_REV_TOL:     rev_tol_reg    <= cfg_data;
                REG_REV_LIMIT:   rev_limit_reg  <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Tracking and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tp_reg       <= '0;
            skip_cnt_reg <= '0;
            ww_cnt_reg   <= '0;
            fault_reg    <= FAULT_NONE;
            voting_reg   <= 1'b1;
            fill_reg     <= '0;
            res_emit_reg <= 1'b0;
        end else begin
            if (cmd.take) begin
                res_emit_reg <= 1'b0;
            end
            // Restart: clear fault and counters, collect a new vote
            if (cmd.restart) begin
                fault_reg    <= FAULT_NONE;
                voting_reg   <= 1'b1;
                fill_reg     <= '0;
                skip_cnt_reg <= '0;
                ww_cnt_reg   <= '0;
            end
            // Advance the fill count
            if (cmd.vote_wr) begin
                fill_reg <= sts.fill_last ? '0 : fill_reg + VOTE_AW'(1);
            end
            // Close the vote
            if (cmd.vote_done) begin
                tp_reg     <= best_reg;
                voting_reg <= 1'b0;
                fill_reg   <= '0;
            end
            // Apply a tracked reading
            if (cmd.track) begin
                if (fault_n != FAULT_NONE) begin
                    fault_reg    <= fault_n;
                    voting_reg   <= 1'b1;
                    fill_reg     <= '0;
                    skip_cnt_reg <= '0;
                    ww_cnt_reg   <= '0;
                    res_emit_reg <= 1'b0;
                end else begin
                    skip_cnt_reg <= skip_n;
                    ww_cnt_reg   <= ww_n;
                    res_emit_reg <= accept || hold;
                    if (accept) begin
                        tp_reg <= reading_reg;
                    end
                end
            end
        end
    end

    // Payload registers: input, skip limit product, vote walk, output
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            reading_reg <= s_reading;
            lim_reg     <= LIM_W'(skip_tol_reg) * LIM_W'(skip_cnt_reg + CNT_W'(1));
        end
        if (cmd.vote_init) begin
            i_reg      <= '0;
            best_n_reg <= '0;
        end
        if (cmd.ld_cur) begin
            cur_reg <= ram_rd_data;
            j_reg   <= '0;
            n_reg   <= '0;
        end
        if (cmd.count) begin
            if (sts.j_last) begin
                if (n_sum > best_n_reg) begin
                    best_n_reg <= n_sum;
                    best_reg   <= cur_reg;
                end
                i_reg <= i_reg + VOTE_AW'(1);
            end else begin
                j_reg <= j_reg + VOTE_AW'(1);
                n_reg <= n_sum;
            end
        end
        // Output register
        if (cmd.load_out) begin
            m_emit_reg       <= res_emit_reg;
            m_position_reg   <= res_emit_reg ? reading_reg : '0;
            m_faulted_reg    <= (fault_reg != FAULT_NONE);
            m_fault_kind_reg <= fault_reg;
        end
    end

    assign sts.faulted   = (fault_reg != FAULT_NONE);
    assign sts.voting    = voting_reg;
    assign sts.fill_last = (fill_reg == VOTE_AW'(VOTE_COUNT - 1));
    assign sts.j_last    = (j_reg == i_reg);
    assign sts.i_last    = (i_reg == VOTE_AW'(VOTE_COUNT - 1));

    assign m_emit       = m_emit_reg;
    assign m_position   = m_position_reg;
    assign m_faulted    = m_faulted_reg;
    assign m_fault_kind = m_fault_kind_reg;

endmodule

@@ hw/rtl/esv_checker.sv @@
// ----------------------------------------------------------------------------
// Encoder sample validator checker
// Port-level assertions, attached to the top level by bind.
// ----------------------------------------------------------------------------
module esv_checker
    import esv_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_emit,
    input logic [POS_W-1:0]      m_position,
    input logic                  m_faulted,
    input logic [FAULT_W-1:0]    m_fault_kind
);
    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position) && $stable(m_emit)
                                && $stable(m_fault_kind))
        else $error("stalled result changed");

    // One item in work: no transfer right after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

    // Position is zero unless emitted
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_emit |-> m_position == '0)
        else $error("position without emit");

    // Faulted flag agrees with fault kind, and a faulted result emits nothing
    a_fault_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_faulted == (m_fault_kind != FAULT_NONE))
                    && !(m_faulted && m_emit))
        else $error("fault flag inconsistent");

    // Fault kind is a defined code
    a_fault_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_fault_kind == FAULT_NONE || m_fault_kind == FAULT_SKIP
                    || m_fault_kind == FAULT_DIR)
        else $error("undefined fault kind");

endmodule

bind encoder_sample_validator esv_checker u_esv_checker (.*);

@@ tb/tb_encoder_sample_validator.sv @@
// ----------------------------------------------------------------------------
// Encoder sample validator testbench
// Drives readings and restarts into encoder_sample_validator and predicts
// every result with a behavioral tracker. The tracker covers the startup
// vote and its tie rule, the wrapped delta, skip and wrong-way counting, the
// backward hold and fault latching. Directed cases come first. Random
// traffic follows in phases, each with its own register setting and one of
// four idle patterns. Each result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_encoder_sample_validator;
    timeunit 1ns;
    timeprecision 1ps;

    import esv_pkg::*;

    localparam int RANDOM_PER_PHASE = 228;
    localparam int PHASES           = 8;
    localparam int HOLDOFF_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES     = 64;
    localparam int IDLE_MARGIN      = 4;

    typedef struct packed {
        logic               emit;
        logic [POS_W-1:0]   position;
        logic               faulted;
        logic [FAULT_W-1:0] kind;
    } sample_result_t;

    // DUT ports
    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_op;
    logic [POS_W-1:0]      s_reading;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_emit;
    logic [POS_W-1:0]      m_position;
    logic                  m_faulted;
    logic [FAULT_W-1:0]    m_fault_kind;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Tracker registers
    logic [TOL_W-1:0]      cfg_skip_tol;
    logic [LIMIT_W-1:0]    cfg_skip_lim;
    logic                  cfg_enforce;
    logic                  cfg_rot_sense;
    logic [TOL_W-1:0]      cfg_rev_tol;
    logic [LIMIT_W-1:0]    cfg_rev_lim;

    // Tracker state
    logic [POS_W-1:0]      trk_point;
    int                    trk_skips;
    int                    trk_wrong;
    logic [FAULT_W-1:0]    trk_fault;
    logic                  trk_voting;
    int                    trk_fill;
    logic [POS_W-1:0]      trk_votes [VOTE_COUNT];

    sample_result_t        pending_results [$];
    int                    mismatch_count = 0;
    int                    stall_cycles = 0;
    int                    src_idle_pct = 0;
    int                    sink_stall_pct = 0;
    bit                    holdoff_req = 1'b0;
    logic [POS_W-1:0]      vote_base = '0;

    encoder_sample_validator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_reading    (s_reading),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_emit       (m_emit),
        .m_position   (m_position),
        .m_faulted    (m_faulted),
        .m_fault_kind (m_fault_kind),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Tracker
    // ------------------------------------------------------------------
    function automatic void rearm_tracker();
        trk_voting = 1'b1;
        trk_fill   = 0;
        trk_skips  = 0;
        trk_wrong  = 0;
    endfunction

    function automatic void reset_tracker();
        cfg_skip_tol  = TOL_W'(1);
        cfg_skip_lim  = LIMIT_W'(1);
        cfg_enforce   = 1'b0;
        cfg_rot_sense = 1'b0;
        cfg_rev_tol   = TOL_W'(1);
        cfg_rev_lim   = LIMIT_W'(1);
        trk_point     = '0;
        trk_fault     = FAULT_NONE;
        rearm_tracker();
    endfunction

    function automatic sample_result_t predict_sample(input logic op,
                                                     input logic [POS_W-1:0] rd);
        sample_result_t   res;
        logic [POS_W-1:0] diff;
        logic [POS_W-1:0] best;
        int               best_n;
        int               n;
        int               dx;
        int               fwd;
        int               lim;
        bit               accept;
        bit               hold;
        res    = '0;
        accept = 1'b0;
        hold   = 1'b0;
        if (op == OP_RESTART) begin
            trk_fault = FAULT_NONE;
            rearm_tracker();
        end else if (trk_fault == FAULT_NONE) begin
            if (trk_voting) begin
                if (trk_fill < VOTE_COUNT)
                    trk_votes[trk_fill] = rd;
                trk_fill++;
                if (trk_fill >= VOTE_COUNT) begin
                    // most frequent value; the first to reach the top count wins
                    best   = trk_votes[0];
                    best_n = 0;
                    for (int i = 0; i < VOTE_COUNT; i++) begin
                        n = 0;
                        for (int j = 0; j <= i; j++)
                            if (trk_votes[j] == trk_votes[i])
                                n++;
                        if (n > best_n) begin
                            best_n = n;
                            best   = trk_votes[i];
                        end
                    end
                    trk_point  = best;
                    trk_voting = 1'b0;
                    trk_fill   = 0;
                end
            end else begin
                // wrapped delta in (-HALF_RES, HALF_RES]
                diff = rd - trk_point;
                dx   = int'(diff);
                if (dx > HALF_RES)
                    dx -= RESOLUTION;
                lim = int'(cfg_skip_tol) * (trk_skips + 1);
                if (cfg_enforce) begin
                    fwd = cfg_rot_sense ? -dx : dx;
                    if (fwd > lim)
                        trk_skips++;
                    else if (fwd < 0) begin
                        if (-fwd > int'(cfg_rev_tol))
                            trk_wrong++;
                        else
                            hold = 1'b1;
                    end else
                        accept = 1'b1;
                end else begin
                    if (dx > lim || dx < -lim)
                        trk_skips++;
                    else
                        accept = 1'b1;
                end
                if (accept || hold) begin
                    trk_skips    = 0;
                    trk_wrong    = 0;
                    res.emit     = 1'b1;
                    res.position = rd;
                    if (accept)
                        trk_point = rd;
                end
                // skip fault has priority over wrong-way fault
                if (trk_skips > int'(cfg_skip_lim)) begin
                    trk_fault = FAULT_SKIP;
                    rearm_tracker();
                    res.emit     = 1'b0;
                    res.position = '0;
                end else if (trk_wrong > int'(cfg_rev_lim)) begin
                    trk_fault = FAULT_DIR;
                    rearm_tracker();
                    res.emit     = 1'b0;
                    res.position = '0;
                end
            end
        end
        res.faulted = (trk_fault != FAULT_NONE);
        res.kind    = trk_fault;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [POS_W-1:0] rd);
        @(negedge aclk);
        // insert random sender gaps
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_reading <= rd;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_results.push_back(predict_sample(op, rd));
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_SKIP_TOL:    cfg_skip_tol  = value[TOL_W-1:0];
            REG_SKIP_LIMIT:  cfg_skip_lim  = value[LIMIT_W-1:0];
            REG_ENFORCE_DIR: cfg_enforce   = value[0];
            REG_ROT_SENSE:   cfg_rot_sense = value[0];
            REG_REV_TOL:     cfg_rev_tol   = value[TOL_W-1:0];
            REG_REV_LIMIT:   cfg_rev_lim   = value[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_registers(input int skip_tol, input int skip_lim,
                                     input int enforce, input int sense,
                                     input int rev_tol, input int rev_lim);
        cfg_write(REG_SKIP_TOL, skip_tol);
        cfg_write(REG_SKIP_LIMIT, skip_lim);
        cfg_write(REG_ENFORCE_DIR, enforce);
        cfg_write(REG_ROT_SENSE, sense);
        cfg_write(REG_REV_TOL, rev_tol);
        cfg_write(REG_REV_LIMIT, rev_lim);
    endtask

    // Drop valid and hold until every expected result has been returned
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (IDLE_MARGIN) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Vote with a tie, wrapped deltas around zero, skip growth and skip fault
    task automatic test_vote_and_skip();
        logic [POS_W-1:0] votes [VOTE_COUNT] = '{7, 3, 3, 7, 9, 9, 12, 13};
        logic [POS_W-1:0] track [10] = '{4, 2, 2, 16383, 0, 16383, 0, 8192, 8192, 100};
        // 3 reaches two votes before 7 does, so 3 wins the tie
        foreach (votes[i])
            send_item(OP_READING, votes[i]);
        // step within tolerance, skip then wider window, wrap below zero,
        // half-turn delta twice to latch the skip fault, then an ignored reading
        foreach (track[i])
            send_item(OP_READING, track[i]);
        send_item(OP_RESTART, 14'h3FFF);
    endtask

    // Backward hold, wrong-way counting and direction fault under enforcement
    task automatic test_direction();
        logic [POS_W-1:0] track [6] = '{90, 93, 92, 95, 96, 50};
        wait_idle();
        program_registers(8191, 255, 1, 1, 2, 1);
        repeat (VOTE_COUNT) send_item(OP_READING, 100);
        foreach (track[i])
            send_item(OP_READING, track[i]);
        send_item(OP_RESTART, 0);
    endtask

    // Well-formed vote and tracking sequences with noise and restarts
    task automatic test_random_phase(input int phase);
        int               kind;
        int               dir;
        int               lim;
        int               mag;
        int               step;
        logic             op;
        logic [POS_W-1:0] rd;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // long receiver hold-off while the sender keeps offering
            if (phase == 2 && n == 60)
                holdoff_req = 1'b1;
            // sender pause until the pipeline is empty
            if (phase == 5 && n == RANDOM_PER_PHASE / 2)
                wait_idle();
            op   = OP_READING;
            rd   = POS_W'($urandom);
            kind = $urandom_range(99);
            if (trk_fault != FAULT_NONE) begin
                if (kind < 70)
                    op = OP_RESTART;
            end else if (trk_voting) begin
                if (trk_fill == 0)
                    vote_base = POS_W'($urandom);
                if (kind < 3)
                    op = OP_RESTART;
                else if (kind < 70)
                    rd = vote_base;
                else if (kind < 90)
                    rd = vote_base + POS_W'($urandom_range(1, 2));
            end else begin
                lim = int'(cfg_skip_tol) * (trk_skips + 1);
                dir = cfg_rot_sense ? -1 : 1;
                if (!cfg_enforce && $urandom_range(1) == 1)
                    dir = -dir;
                if (kind < 4)
                    op = OP_RESTART;
                else if (kind >= 10) begin
                    if (kind < 50)
                        mag = int'($urandom_range(cfg_skip_tol));
                    else if (kind < 62)
                        mag = lim - 1 + int'($urandom_range(2));
                    else if (kind < 76)
                        mag = -int'($urandom_range(cfg_rev_tol));
                    else if (kind < 88)
                        mag = -(int'(cfg_rev_tol) + int'($urandom_range(3)));
                    else
                        mag = int'($urandom_range(2 * lim, lim));
                    // keep the step within half a turn
                    if (mag > HALF_RES)
                        mag = HALF_RES;
                    if (mag < -HALF_RES)
                        mag = -HALF_RES;
                    step = dir * mag;
                    rd   = trk_point + step[POS_W-1:0];
                end
            end
            send_item(op, rd);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_failure(input string msg);
        if (mismatch_count < 10)
            $display("%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        sample_result_t got;
        sample_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_emit, m_position, m_faulted, m_fault_kind};
            if (pending_results.size() == 0) begin
                report_failure($sformatf("unexpected result emit=%0d pos=%0d %s",
                                         got.emit, got.position,
                                         $sformatf("faulted=%0d kind=%0d",
                                                   got.faulted, got.kind)));
            end else begin
                want = pending_results.pop_front();
                if (got.emit !== want.emit || got.position !== want.position ||
                    got.faulted !== want.faulted || got.kind !== want.kind) begin
                    report_failure({
                        $sformatf("result differs: expected emit=%0d pos=%0d ",
                                  want.emit, want.position),
                        $sformatf("faulted=%0d kind=%0d, ", want.faulted, want.kind),
                        $sformatf("got emit=%0d pos=%0d faulted=%0d kind=%0d",
                                  got.emit, got.position, got.faulted, got.kind)});
                end
            end
        end
    end

    // Count cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holdoff_req) begin
                m_ready <= 1'b0;
                for (int c = 0; c < HOLDOFF_CYCLES; c++)
                    @(negedge aclk);
                holdoff_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_op      = OP_READING;
        s_reading = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_SKIP_TOL;
        cfg_data  = '0;
        reset_tracker();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_vote_and_skip();
        test_direction();

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: program_registers(1, 1, 0, 0, 1, 1);
                1: program_registers(8191, 255, 1, 1, 8191, 255);
                2: program_registers(40, 2, 1, 0, 10, 1);
                3: program_registers(8191, 1, 0, 1, 8191, 1);
                default: program_registers($urandom_range(300, 1), $urandom_range(4, 1),
                                           $urandom_range(1), $urandom_range(1),
                                           $urandom_range(100, 1), $urandom_range(4, 1));
            endcase
            // rotate through the idle patterns
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
                default: begin src_idle_pct = 14; sink_stall_pct = 14; end
            endcase
            test_random_phase(ph);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/esv_pkg.sv
hw/rtl/esv_ram.sv
hw/rtl/esv_ctrl.sv
hw/rtl/esv_dp.sv
hw/rtl/encoder_sample_validator.sv
hw/rtl/esv_checker.sv
tb/tb_encoder_sample_validator.sv
